### design/crsf_pkg.sv
package crsf_pkg;

  // Default store depth; the top level hands this down as MAX_FRAME.
  localparam int MAX_FRAME_DEF = 64;

  // Largest payload the frame format allows, whatever the store depth.
  localparam int ABS_PAYLOAD_CAP = 60;

  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Register reset values.
  localparam logic [7:0] ADDR_ONE_RST = 8'd234;
  localparam logic [7:0] ADDR_TWO_RST = 8'd238;
  localparam logic [5:0] MAX_PL_RST   = 6'd60;
  localparam logic [7:0] TIMEOUT_RST  = 8'd10;

  // Input item kinds, carried on in_tuser.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    CFG_ADDR_ONE = 2'd0,
    CFG_ADDR_TWO = 2'd1,
    CFG_MAX_PL   = 2'd2,
    CFG_TIMEOUT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ADDR,
    ST_LEN,
    ST_TYPE,
    ST_PAYLOAD,
    ST_CRC,
    ST_REPLAY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;       // one millisecond tick accepted
    logic byte_seen;  // a byte was accepted
    logic wr_first;   // store address byte at entry zero
    logic wr_len;     // store length byte, load frame length and payload target
    logic wr_next;    // store type, payload or CRC byte at the write index
    logic crc_init;   // start the CRC with the type byte
    logic crc_upd;    // fold a payload byte into the CRC
    logic crc_chk;    // compare the CRC byte and arm the replay
    logic rd_issue;   // read one stored byte for the replay
  } crsf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_match;
    logic len_ok;
    logic timeout;
    logic payload_last;
    logic rd_last;
    logic rd_pend;
    logic out_free;
  } crsf_sts_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### design/crsf_frame_receiver_core.sv
// Channel | Direction | Transaction carries
// --------+-----------+---------------------------------------------------------
// in_     | input     | one received byte, or one millisecond tick (in_tuser)
// out_    | output    | one byte of a completed frame, crc_ok flag, frame length
// cfg_    | input     | one register write: index and data
//
// A received byte or tick is taken whenever in_tready is high. Once the CRC
// byte of a frame arrives, the frame is replayed from the frame store through
// the store's registered read port and then the output register; no new read
// is issued while one is pending, and in_tready is low until the last read has
// been issued. Reset is synchronous on rst_n low and clears the parser state and
// the registers to their defaults; the frame store needs no clearing. A stall on
// out_tready holds the output register and pauses the replay.
module crsf_frame_receiver_core #(
  parameter int MAX_FRAME = crsf_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] operation: 0 byte, 1 millisecond tick
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] frame_byte, [14:8] frame_length, [15] zero
  output logic        out_tuser,  // [0] crc_ok
  output logic        out_tlast,  // set on the CRC byte, the last of the frame
  // Register writes; always taken.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  crsf_pkg::crsf_cmd_t cmd;
  crsf_pkg::crsf_sts_t sts;
  logic [7:0] out_byte;
  logic [6:0] out_len;

  // The controller sequences the frame phases and the replay; the datapath holds
  // the registers, counters, CRC, frame store and output register.
  crsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  crsf_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .rx_byte    (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_byte),
    .out_crc_ok (out_tuser),
    .out_len    (out_len),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, out_len, out_byte};
  assign cfg_ready = 1'b1;

endmodule

### design/crsf_ram.sv
module crsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/crsf_dp.sv
module crsf_dp #(
  parameter int MAX_FRAME = crsf_pkg::MAX_FRAME_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crsf_pkg::crsf_cmd_t cmd,
  output crsf_pkg::crsf_sts_t sts,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_crc_ok,
  output logic [6:0]          out_len,
  output logic                out_last
);

  localparam int ADDR_W  = $clog2(MAX_FRAME);
  localparam int CAP_RAW = MAX_FRAME - 4;
  localparam int CAP_C   = (CAP_RAW < crsf_pkg::ABS_PAYLOAD_CAP) ? CAP_RAW
                                                                 : crsf_pkg::ABS_PAYLOAD_CAP;

  logic [7:0] addr_one_r, addr_two_r, timeout_r;
  logic [5:0] max_pl_r;
  logic [7:0] idle_r, idle_nxt;
  logic       seen_r, seen_nxt;
  logic [ADDR_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] tgt_r, tgt_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic [6:0] flen_r;
  logic       crc_ok_r;
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [6:0] rem_r, rem_nxt;
  logic       rd_pend_r, rd_last_pend_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_last_r, out_crc_r;
  logic [6:0] out_len_r;

  logic [5:0] cap;
  logic       ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0] ram_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_one_r <= crsf_pkg::ADDR_ONE_RST;
      addr_two_r <= crsf_pkg::ADDR_TWO_RST;
      max_pl_r   <= crsf_pkg::MAX_PL_RST;
      timeout_r  <= crsf_pkg::TIMEOUT_RST;
    end else if (cfg_valid) begin
      case (crsf_pkg::cfg_reg_t'(cfg_index))
        crsf_pkg::CFG_ADDR_ONE: addr_one_r <= cfg_data;
        crsf_pkg::CFG_ADDR_TWO: addr_two_r <= cfg_data;
        crsf_pkg::CFG_MAX_PL:   max_pl_r   <= cfg_data[5:0];
        crsf_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cap = (max_pl_r > 6'(CAP_C)) ? 6'(CAP_C) : max_pl_r;

  always_comb begin
    idle_nxt = idle_r;
    seen_nxt = seen_r;
    if (cmd.tick && idle_r != 8'hFF) begin
      idle_nxt = idle_r + 8'd1;
    end
    if (cmd.byte_seen) begin
      idle_nxt = '0;
      seen_nxt = 1'b1;
    end

    wr_idx_nxt = wr_idx_r;
    if (cmd.wr_first) begin
      wr_idx_nxt = ADDR_W'(1);
    end else if (cmd.wr_len || cmd.wr_next) begin
      wr_idx_nxt = wr_idx_r + ADDR_W'(1);
    end

    cnt_nxt = cnt_r;
    tgt_nxt = tgt_r;
    if (cmd.wr_len) begin
      cnt_nxt = '0;
      tgt_nxt = rx_byte[5:0] - 6'd2;
    end else if (cmd.crc_upd) begin
      cnt_nxt = cnt_r + 6'd1;
    end

    crc_nxt = crc_r;
    if (cmd.crc_init) begin
      crc_nxt = crsf_pkg::crc8_update(8'h00, rx_byte);
    end else if (cmd.crc_upd) begin
      crc_nxt = crsf_pkg::crc8_update(crc_r, rx_byte);
    end

    rd_idx_nxt = rd_idx_r;
    rem_nxt    = rem_r;
    if (cmd.crc_chk) begin
      rd_idx_nxt = '0;
      rem_nxt    = flen_r;
    end else if (cmd.rd_issue) begin
      rd_idx_nxt = rd_idx_r + ADDR_W'(1);
      rem_nxt    = rem_r - 7'd1;
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r      <= '0;
      seen_r      <= 1'b0;
      wr_idx_r    <= '0;
      cnt_r       <= '0;
      tgt_r       <= '0;
      crc_r       <= '0;
      rd_idx_r    <= '0;
      rem_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idle_r      <= idle_nxt;
      seen_r      <= seen_nxt;
      wr_idx_r    <= wr_idx_nxt;
      cnt_r       <= cnt_nxt;
      tgt_r       <= tgt_nxt;
      crc_r       <= crc_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rem_r       <= rem_nxt;
      rd_pend_r   <= cmd.rd_issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Frame bookkeeping and the output register carry data only.
  always_ff @(posedge clk) begin
    if (cmd.wr_len) begin
      flen_r <= rx_byte[6:0] + 7'd2;
    end
    if (cmd.crc_chk) begin
      crc_ok_r <= (crc_r == rx_byte);
    end
    rd_last_pend_r <= sts.rd_last;
    if (rd_pend_r) begin
      out_byte_r <= ram_q;
      out_last_r <= rd_last_pend_r;
      out_len_r  <= flen_r;
      out_crc_r  <= crc_ok_r;
    end
  end

  assign ram_we    = cmd.wr_first || cmd.wr_len || cmd.wr_next;
  assign ram_waddr = cmd.wr_first ? '0 : wr_idx_r;

  crsf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rx_byte),
    .re    (cmd.rd_issue),
    .raddr (rd_idx_r),
    .rdata (ram_q)
  );

  always_comb begin
    sts.addr_match   = (rx_byte == addr_one_r) || (rx_byte == addr_two_r);
    sts.len_ok       = (rx_byte >= 8'd3) && ({1'b0, rx_byte} <= ({3'b000, cap} + 9'd2));
    sts.timeout      = seen_r && (idle_r > timeout_r);
    sts.payload_last = ({1'b0, cnt_r} + 7'd1) >= {1'b0, tgt_r};
    sts.rd_last      = (rem_r == 7'd1);
    sts.rd_pend      = rd_pend_r;
    sts.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_crc_ok = out_crc_r;
  assign out_len    = out_len_r;
  assign out_last   = out_last_r;

endmodule

### design/crsf_ctrl.sv
module crsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  input  crsf_pkg::crsf_sts_t sts,
  output crsf_pkg::crsf_cmd_t cmd
);

  crsf_pkg::state_t state_r, state_nxt, eff_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crsf_pkg::ST_ADDR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r != crsf_pkg::ST_REPLAY);

    // A stale frame is abandoned before the new byte is looked at.
    eff_state = (state_r != crsf_pkg::ST_ADDR && sts.timeout) ? crsf_pkg::ST_ADDR : state_r;

    if (state_r == crsf_pkg::ST_REPLAY) begin
      if (!sts.rd_pend && sts.out_free) begin
        cmd.rd_issue = 1'b1;
        if (sts.rd_last) begin
          state_nxt = crsf_pkg::ST_ADDR;
        end
      end
    end else if (in_valid && in_op == crsf_pkg::OP_TICK) begin
      cmd.tick = 1'b1;
    end else if (in_valid) begin
      cmd.byte_seen = 1'b1;
      state_nxt     = eff_state;
      case (eff_state)
        crsf_pkg::ST_ADDR: begin
          if (sts.addr_match) begin
            cmd.wr_first = 1'b1;
            state_nxt    = crsf_pkg::ST_LEN;
          end
        end
        crsf_pkg::ST_LEN: begin
          if (sts.len_ok) begin
            cmd.wr_len = 1'b1;
            state_nxt  = crsf_pkg::ST_TYPE;
          end else begin
            state_nxt = crsf_pkg::ST_ADDR;
          end
        end
        crsf_pkg::ST_TYPE: begin
          cmd.wr_next  = 1'b1;
          cmd.crc_init = 1'b1;
          state_nxt    = crsf_pkg::ST_PAYLOAD;
        end
        crsf_pkg::ST_PAYLOAD: begin
          cmd.wr_next = 1'b1;
          cmd.crc_upd = 1'b1;
          if (sts.payload_last) begin
            state_nxt = crsf_pkg::ST_CRC;
          end
        end
        crsf_pkg::ST_CRC: begin
          cmd.wr_next = 1'b1;
          cmd.crc_chk = 1'b1;
          state_nxt   = crsf_pkg::ST_REPLAY;
        end
        default: begin
          state_nxt = crsf_pkg::ST_ADDR;
        end
      endcase
    end
  end

endmodule

### design/crsf_checker.sv
module crsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reported frame lengths stay within the format's limits.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:8] >= 7'd4 && out_tdata[14:8] <= 7'd64 && !out_tdata[15])
    else $error("frame length out of range");

  // While a frame is partly delivered, no new input is taken.
  a_replay_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken during frame replay");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind crsf_frame_receiver_core crsf_checker u_crsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

### tb/crsf_frame_receiver_core_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the frame receiver. One initial block runs the named
// tests in turn. Every test feeds bytes and millisecond ticks through a shared
// sender task. The sender updates a shadow copy of the parser as each input
// transaction is accepted. The shadow parser queues one expected frame byte for
// every byte that the block should replay. A separate process pops that queue
// on each output transaction and compares the fields one by one.
module crsf_frame_receiver_core_tb;

  // Cycles allowed after the last expected byte. This covers the item that was
  // just accepted, the read pipeline and the output register.
  localparam int SETTLE_CYCLES = 8;

  typedef logic [7:0] byte_q_t[$];

  // One replayed frame byte as the block should present it.
  typedef struct {
    logic [7:0] frame_byte;
    logic       crc_ok;
    logic [6:0] frame_length;
    logic       last;
  } frame_beat_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic [7:0]          in_tdata   = 8'h00;
  logic                in_tuser   = crsf_pkg::OP_BYTE;
  logic                out_tready = 1'b0;
  logic                cfg_valid  = 1'b0;
  crsf_pkg::cfg_reg_t  cfg_index  = crsf_pkg::CFG_ADDR_ONE;
  logic [7:0]          cfg_data   = 8'h00;
  wire                 in_tready;
  wire                 out_tvalid;
  wire  [15:0]         out_tdata;
  wire                 out_tuser;
  wire                 out_tlast;
  wire                 cfg_ready;

  crsf_frame_receiver_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the registers.
  logic [7:0] rx_addr_one;
  logic [7:0] rx_addr_two;
  logic [5:0] rx_max_payload;
  logic [7:0] rx_timeout;

  // Shadow copy of the parser.
  crsf_pkg::state_t parse_state;
  byte_q_t          frame_bytes;
  int unsigned      payload_seen;
  int unsigned      payload_want;
  logic [7:0]       crc_acc;
  int unsigned      idle_ticks;
  bit               byte_seen_once;

  frame_beat_t beats_pending[$];
  int          mismatches    = 0;
  int          beats_checked = 0;
  int          items_sent    = 0;
  // When steady is set, neither side inserts gaps.
  bit          steady        = 1'b0;
  // A nonzero value asks the sink to hold out_tready low for that many cycles.
  int          hold_req      = 0;
  int          hold_left     = 0;
  int          stall_left    = 0;

  // CRC-8, polynomial 0xD5, processed one bit at a time from the MSB.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ crsf_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  // The payload limit in force. The register is bounded by the store depth and
  // by the format's own ceiling.
  function automatic int shadow_cap();
    int cap;
    cap = int'(rx_max_payload);
    if (cap > crsf_pkg::MAX_FRAME_DEF - 4) begin
      cap = crsf_pkg::MAX_FRAME_DEF - 4;
    end
    if (cap > crsf_pkg::ABS_PAYLOAD_CAP) begin
      cap = crsf_pkg::ABS_PAYLOAD_CAP;
    end
    return cap;
  endfunction

  function automatic void reset_shadow();
    rx_addr_one    = crsf_pkg::ADDR_ONE_RST;
    rx_addr_two    = crsf_pkg::ADDR_TWO_RST;
    rx_max_payload = crsf_pkg::MAX_PL_RST;
    rx_timeout     = crsf_pkg::TIMEOUT_RST;
    parse_state    = crsf_pkg::ST_ADDR;
    frame_bytes.delete();
    payload_seen   = 0;
    payload_want   = 0;
    crc_acc        = 8'h00;
    idle_ticks     = 0;
    byte_seen_once = 1'b0;
  endfunction

  // Advance the shadow parser by one accepted input transaction. When the CRC
  // byte completes a frame, queue one expected beat for every stored byte.
  function automatic void predict_item(input logic op, input logic [7:0] b);
    frame_beat_t beat;
    logic        ok;
    if (op == crsf_pkg::OP_TICK) begin
      if (idle_ticks < 255) begin
        idle_ticks++;
      end
      return;
    end
    // If the link went quiet for too long mid-frame, drop the partial frame.
    // The new byte is then examined as a possible address byte.
    if (byte_seen_once && parse_state != crsf_pkg::ST_ADDR && idle_ticks > rx_timeout) begin
      parse_state = crsf_pkg::ST_ADDR;
    end
    idle_ticks     = 0;
    byte_seen_once = 1'b1;
    case (parse_state)
      crsf_pkg::ST_ADDR: begin
        if (b == rx_addr_one || b == rx_addr_two) begin
          frame_bytes.delete();
          frame_bytes.push_back(b);
          parse_state = crsf_pkg::ST_LEN;
        end
      end
      crsf_pkg::ST_LEN: begin
        // A bad length drops the frame and is not itself treated as an address.
        if (b < 3 || b > shadow_cap() + 2) begin
          parse_state = crsf_pkg::ST_ADDR;
        end else begin
          frame_bytes.push_back(b);
          payload_want = b - 2;
          payload_seen = 0;
          parse_state  = crsf_pkg::ST_TYPE;
        end
      end
      crsf_pkg::ST_TYPE: begin
        frame_bytes.push_back(b);
        crc_acc     = crc_fold(8'h00, b);
        parse_state = crsf_pkg::ST_PAYLOAD;
      end
      crsf_pkg::ST_PAYLOAD: begin
        frame_bytes.push_back(b);
        crc_acc = crc_fold(crc_acc, b);
        payload_seen++;
        if (payload_seen >= payload_want) begin
          parse_state = crsf_pkg::ST_CRC;
        end
      end
      crsf_pkg::ST_CRC: begin
        frame_bytes.push_back(b);
        parse_state = crsf_pkg::ST_ADDR;
        ok = (crc_acc == b);
        foreach (frame_bytes[k]) begin
          beat.frame_byte   = frame_bytes[k];
          beat.crc_ok       = ok;
          beat.frame_length = 7'(frame_bytes.size());
          beat.last         = (k == frame_bytes.size() - 1);
          beats_pending.push_back(beat);
        end
      end
      default: begin
        parse_state = crsf_pkg::ST_ADDR;
      end
    endcase
  endfunction

  // Gap length for either side. Most gaps are empty or short, and a few gaps
  // are long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_addr();
    return $urandom_range(0, 1) ? rx_addr_two : rx_addr_one;
  endfunction

  function automatic byte_q_t random_body(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t: frame byte %0d, %s: got 0x%0h, expected 0x%0h",
               $time, beats_checked, what, got, want);
    end
  endtask

  // Sends one input transaction. tvalid stays high after the handshake. The
  // next call either drives the next item at once or lowers tvalid for a gap.
  // The two assignments therefore never fall in the same time step.
  task automatic send_item(input logic op, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(op, b);
    items_sent++;
  endtask

  // The data bits are ignored for a tick, so they carry random values.
  task automatic send_ticks(input int n);
    repeat (n) send_item(crsf_pkg::OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Sends address, length, body (type plus payload) and CRC. Up to tick_max
  // ticks may fall between bytes at random.
  task automatic send_frame(input logic [7:0] addr, input byte_q_t body, input bit crc_good,
                            input int tick_max);
    logic [7:0] crc;
    byte_q_t    line_bytes;
    crc = 8'h00;
    foreach (body[i]) crc = crc_fold(crc, body[i]);
    if (!crc_good) begin
      crc = crc ^ 8'($urandom_range(1, 255));
    end
    line_bytes.push_back(addr);
    line_bytes.push_back(8'(body.size() + 1));
    foreach (body[i]) line_bytes.push_back(body[i]);
    line_bytes.push_back(crc);
    foreach (line_bytes[i]) begin
      if (i != 0 && tick_max != 0 && $urandom_range(0, 3) == 0) begin
        send_ticks($urandom_range(0, tick_max));
      end
      send_item(crsf_pkg::OP_BYTE, line_bytes[i]);
    end
  endtask

  // Stop offering input, wait for every expected frame byte, then let the block
  // finish any item that leaves no result.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (beats_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write transaction. Callers make sure that the block is idle.
  task automatic write_reg(input crsf_pkg::cfg_reg_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      crsf_pkg::CFG_ADDR_ONE: rx_addr_one    = val;
      crsf_pkg::CFG_ADDR_TWO: rx_addr_two    = val;
      crsf_pkg::CFG_MAX_PL:   rx_max_payload = val[5:0];
      crsf_pkg::CFG_TIMEOUT:  rx_timeout     = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mixed traffic under the current settings. Most of it is well-formed frames
  // with random content, some with a bad CRC. The rest is stray bytes, bad
  // lengths, frames cut short and left to time out, and bursts of ticks.
  task automatic random_traffic(input int n_items);
    int      stop_at;
    int      r;
    int      cap;
    int      plen;
    int      len;
    byte_q_t body;
    stop_at = items_sent + n_items;
    cap     = shadow_cap();
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 68 && cap != 0) begin
        if ($urandom_range(0, 9) == 0) begin
          plen = $urandom_range(1, cap);
        end else begin
          plen = $urandom_range(1, (cap < 6) ? cap : 6);
        end
        body = random_body(plen + 1);
        send_frame(pick_addr(), body, $urandom_range(0, 7) != 0,
                   (rx_timeout < 4) ? rx_timeout : 4);
      end else if (r < 78) begin
        send_item(crsf_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 86) begin
        send_item(crsf_pkg::OP_BYTE, pick_addr());
        if ($urandom_range(0, 1) == 0) begin
          send_item(crsf_pkg::OP_BYTE, 8'($urandom_range(0, 2)));
        end else begin
          send_item(crsf_pkg::OP_BYTE, 8'($urandom_range(cap + 3, 255)));
        end
      end else if (r < 94 && cap != 0) begin
        // A frame cut short. Unless the timeout is at its ceiling, the link
        // then goes quiet long enough to force a resync.
        len = $urandom_range(3, cap + 2);
        send_item(crsf_pkg::OP_BYTE, pick_addr());
        send_item(crsf_pkg::OP_BYTE, 8'(len));
        repeat ($urandom_range(0, len - 1)) begin
          send_item(crsf_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        end
        if (rx_timeout < 255) begin
          send_ticks(rx_timeout + 1);
        end
      end else begin
        send_ticks($urandom_range(1, 3));
      end
    end
  endtask

  // Default settings: stray bytes before any frame, a good and a bad CRC with
  // all-zero and all-one content, lengths too short, too long and equal to an
  // address, and a good frame right after the rejects.
  task automatic test_defaults_directed();
    byte_q_t body;
    send_ticks(2);
    send_item(crsf_pkg::OP_BYTE, 8'h00);
    send_item(crsf_pkg::OP_BYTE, 8'hFF);
    body = {8'h00, 8'hFF};
    send_frame(crsf_pkg::ADDR_ONE_RST, body, 1'b1, 0);
    body = {8'hFF, 8'h00};
    send_frame(crsf_pkg::ADDR_TWO_RST, body, 1'b0, 0);
    send_item(crsf_pkg::OP_BYTE, crsf_pkg::ADDR_ONE_RST);
    send_item(crsf_pkg::OP_BYTE, 8'd2);
    send_item(crsf_pkg::OP_BYTE, crsf_pkg::ADDR_TWO_RST);
    send_item(crsf_pkg::OP_BYTE, crsf_pkg::ADDR_TWO_RST);
    send_item(crsf_pkg::OP_BYTE, 8'h55);
    send_item(crsf_pkg::OP_BYTE, crsf_pkg::ADDR_ONE_RST);
    send_item(crsf_pkg::OP_BYTE, 8'd63);
    body = {8'h5A, 8'hA5};
    send_frame(crsf_pkg::ADDR_TWO_RST, body, 1'b1, 0);
    wait_drained();
  endtask

  task automatic test_random_defaults();
    random_traffic(25);
    wait_drained();
  endtask

  // Addresses at both ends of the byte range. The payload limit is written with
  // its upper bits set, so only the low six bits give a limit of one. The
  // timeout is set to one.
  task automatic test_extreme_settings();
    byte_q_t    body;
    logic [7:0] t_byte;
    logic [7:0] p_byte;
    write_reg(crsf_pkg::CFG_ADDR_ONE, 8'h00);
    write_reg(crsf_pkg::CFG_ADDR_TWO, 8'hFF);
    write_reg(crsf_pkg::CFG_MAX_PL, 8'hC1);
    write_reg(crsf_pkg::CFG_TIMEOUT, 8'd1);
    send_item(crsf_pkg::OP_BYTE, 8'h00);
    send_item(crsf_pkg::OP_BYTE, 8'd4);
    body = random_body(2);
    send_frame(8'hFF, body, 1'b1, 0);
    // One idle tick between bytes is within the limit and the frame completes.
    t_byte = 8'($urandom_range(0, 255));
    p_byte = 8'($urandom_range(0, 255));
    send_item(crsf_pkg::OP_BYTE, 8'h00);
    send_ticks(1);
    send_item(crsf_pkg::OP_BYTE, 8'd3);
    send_ticks(1);
    send_item(crsf_pkg::OP_BYTE, t_byte);
    send_ticks(1);
    send_item(crsf_pkg::OP_BYTE, p_byte);
    send_ticks(1);
    send_item(crsf_pkg::OP_BYTE, crc_fold(crc_fold(8'h00, t_byte), p_byte));
    // Two ticks exceed the limit. The address byte that follows restarts the
    // parser and opens a new frame.
    send_item(crsf_pkg::OP_BYTE, 8'h00);
    send_item(crsf_pkg::OP_BYTE, 8'd3);
    send_item(crsf_pkg::OP_BYTE, 8'h11);
    send_ticks(2);
    body = random_body(2);
    send_frame(8'hFF, body, 1'b1, 0);
    random_traffic(10);
    wait_drained();
  endtask

  // A zero limit rejects every length. The widest limit is written as all ones
  // and clips at 60, which gives the largest frame of 64 bytes.
  task automatic test_payload_cap();
    byte_q_t body;
    write_reg(crsf_pkg::CFG_MAX_PL, 8'h00);
    send_item(crsf_pkg::OP_BYTE, 8'h00);
    send_item(crsf_pkg::OP_BYTE, 8'd3);
    send_item(crsf_pkg::OP_BYTE, 8'hFF);
    send_item(crsf_pkg::OP_BYTE, 8'd2);
    wait_drained();
    write_reg(crsf_pkg::CFG_MAX_PL, 8'hFF);
    body = random_body(crsf_pkg::ABS_PAYLOAD_CAP + 1);
    send_frame(8'hFF, body, 1'b1, 0);
    send_item(crsf_pkg::OP_BYTE, 8'h00);
    send_item(crsf_pkg::OP_BYTE, 8'd63);
    random_traffic(10);
    wait_drained();
  endtask

  // With the longest timeout, a frame survives a long pause between its bytes.
  task automatic test_long_timeout();
    byte_q_t body;
    write_reg(crsf_pkg::CFG_ADDR_ONE, 8'hA5);
    write_reg(crsf_pkg::CFG_ADDR_TWO, 8'h5A);
    write_reg(crsf_pkg::CFG_MAX_PL, 8'd60);
    write_reg(crsf_pkg::CFG_TIMEOUT, 8'd255);
    send_item(crsf_pkg::OP_BYTE, 8'hA5);
    send_item(crsf_pkg::OP_BYTE, 8'd3);
    send_ticks(24);
    body = random_body(2);
    send_item(crsf_pkg::OP_BYTE, body[0]);
    send_item(crsf_pkg::OP_BYTE, body[1]);
    send_item(crsf_pkg::OP_BYTE, crc_fold(crc_fold(8'h00, body[0]), body[1]));
    wait_drained();
  endtask

  // The sink holds off for a long stretch while two frames arrive. The replay
  // of the first frame then backs up and in_tready must drop. Afterwards the
  // sender waits for every frame byte before it continues.
  task automatic test_output_hold();
    byte_q_t body;
    write_reg(crsf_pkg::CFG_TIMEOUT, 8'd3);
    hold_req = 400;
    repeat (2) begin
      body = random_body(6);
      send_frame(pick_addr(), body, 1'b1, 0);
    end
    wait_drained();
    random_traffic(10);
    wait_drained();
  endtask

  // Back-to-back traffic on both sides, with no gaps.
  task automatic test_steady_stream();
    steady = 1'b1;
    random_traffic(15);
    wait_drained();
    steady = 1'b0;
  endtask

  // Sink side: a long hold when a test requests one, otherwise random stalls
  // unless the steady flag is set.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) begin
        stall_left = idle_len();
      end
    end
  end

  // Compare each output transaction with the oldest expected frame byte.
  always @(posedge clk) begin : result_check
    frame_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (beats_pending.size() == 0) begin
        report_mismatch("no frame byte expected", out_tdata, 16'h0000);
      end else begin
        want = beats_pending.pop_front();
        if (out_tdata[7:0] !== want.frame_byte) begin
          report_mismatch("frame_byte", 16'(out_tdata[7:0]), 16'(want.frame_byte));
        end
        if (out_tdata[14:8] !== want.frame_length) begin
          report_mismatch("frame_length", 16'(out_tdata[14:8]), 16'(want.frame_length));
        end
        if (out_tdata[15] !== 1'b0) begin
          report_mismatch("tdata padding", 16'(out_tdata[15]), 16'h0000);
        end
        if (out_tuser !== want.crc_ok) begin
          report_mismatch("crc_ok", 16'(out_tuser), 16'(want.crc_ok));
        end
        if (out_tlast !== want.last) begin
          report_mismatch("last", 16'(out_tlast), 16'(want.last));
        end
      end
      beats_checked++;
    end
  end

  initial begin
    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults_directed();
    test_random_defaults();
    test_extreme_settings();
    test_payload_cap();
    test_long_timeout();
    test_output_hold();
    test_steady_stream();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && beats_pending.size() == 0) begin
      $display("crsf_frame_receiver_core: match");
    end else begin
      $display("crsf_frame_receiver_core: mismatch");
    end
    $finish;
  end

  // Watchdog. A correct run takes a small fraction of this time.
  initial begin
    #50000000;
    $display("crsf_frame_receiver_core: mismatch");
    $finish;
  end

endmodule
